// File: sv/flow_allow_table_with_aging_top_assert.svh
// ----------------------------------------------------------------------------
// Flow allow table assertion macros
// Shorthand for the concurrent checks of the flow allow table top level.
// ----------------------------------------------------------------------------
`ifndef FLOW_ALLOW_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define FLOW_ALLOW_TABLE_WITH_AGING_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/fat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow allow table package
// Shared constants, codes and the scan token type of the flow allow table.
// ----------------------------------------------------------------------------
package fat_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 64;
    localparam logic [15:0] VALIDITY_RESET    = 16'd600;

    typedef enum logic [1:0] {
        FUNC_ALLOW = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        STAT_STORED  = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_ACCEPT  = 3'd2,
        STAT_NOMATCH = 3'd3,
        STAT_TICK    = 3'd4
    } t_status;

    // Flags carried by the scan token from cell to cell.
    typedef struct packed {
        logic active;
        logic hit;
        logic free;
    } t_flags;

endpackage

// File: sv/flow_allow_table_with_aging_top.sv
`timescale 1ns / 1ps
// Allow and query items send the scan token along the row, one cell per cycle, and
// the result then waits in the done state until the output register can take it.
// Tick items and unused function codes go straight to the done state. No new item is taken before the result is loaded.
// Synchronous active-low reset empties every slot, zeroes the seconds counter
// and loads a validity of 600 seconds; there is no clearing pass.
// ----------------------------------------------------------------------------
// Flow allow table with aging
// A row of slot cells holding allowed flows, searched by a token that walks
// the row, with stamps compared against a wrapping seconds counter.
// ----------------------------------------------------------------------------
`include "flow_allow_table_with_aging_top_assert.svh"

module flow_allow_table_with_aging_top #(
    parameter int unsigned TABLE_ENTRIES = fat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_flow_address,
    input  logic [15:0] i_flow_port,
    // Result item channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot_index,
    // Validity register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // The controller is idle, walks the token along the cells, or holds a
    // finished result until the output register can take it.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state           r_state,      n_state;
    fat_pkg::t_func   r_func,       n_func;
    logic [31:0]      r_key_address, n_key_address;
    logic [15:0]      r_key_port,   n_key_port;
    logic [31:0]      r_now,        n_now;
    logic [15:0]      r_validity,   n_validity;
    logic             r_pulse,      n_pulse;
    logic             r_wr_en,      n_wr_en;
    logic [IW-1:0]    r_wr_idx,     n_wr_idx;
    fat_pkg::t_status r_res_status, n_res_status;
    logic [IW-1:0]    r_res_slot,   n_res_slot;
    logic             r_out_valid,  n_out_valid;
    fat_pkg::t_status r_out_status, n_out_status;
    logic [IW-1:0]    r_out_slot,   n_out_slot;

    fat_pkg::t_flags  chain_flags [TABLE_ENTRIES+1];
    logic [IW-1:0]    chain_hit   [TABLE_ENTRIES+1];
    logic [IW-1:0]    chain_free  [TABLE_ENTRIES+1];

    logic             in_acc;
    logic             cfg_acc;
    logic             out_free;
    fat_pkg::t_flags  last_flags;
    logic [31:0]      slot_wide;

    // The token enters the first cell as a one-cycle pulse after acceptance.
    assign chain_flags[0] = '{active: r_pulse, hit: 1'b0, free: 1'b0};
    assign chain_hit[0]   = '0;
    assign chain_free[0]  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        fat_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_flags       (chain_flags[g]),
            .i_hit_idx     (chain_hit[g]),
            .i_free_idx    (chain_free[g]),
            .i_key_address (r_key_address),
            .i_key_port    (r_key_port),
            .i_now         (r_now),
            .i_validity    (r_validity),
            .i_wr_en       (r_wr_en),
            .i_wr_idx      (r_wr_idx),
            .o_flags       (chain_flags[g+1]),
            .o_hit_idx     (chain_hit[g+1]),
            .o_free_idx    (chain_free[g+1])
        );
    end

    assign last_flags = chain_flags[TABLE_ENTRIES];

    assign o_stall     = (r_state != ST_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_stall;

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_key_address = r_key_address;
        n_key_port    = r_key_port;
        n_now         = r_now;
        n_validity    = r_validity;
        n_pulse       = 1'b0;
        n_wr_en       = 1'b0;
        n_wr_idx      = r_wr_idx;
        n_res_status  = r_res_status;
        n_res_slot    = r_res_slot;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;

        if (cfg_acc) begin
            n_validity = i_cfg_data;
        end

        // A taken result frees the output register.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_func        = fat_pkg::t_func'(i_func);
                    n_key_address = i_flow_address;
                    n_key_port    = i_flow_port;
                    n_res_slot    = '0;
                    case (fat_pkg::t_func'(i_func))
                        fat_pkg::FUNC_ALLOW, fat_pkg::FUNC_QUERY: begin
                            n_pulse = 1'b1;
                            n_state = ST_SCAN;
                        end
                        fat_pkg::FUNC_TICK: begin
                            n_now        = r_now + 32'd1;
                            n_res_status = fat_pkg::STAT_TICK;
                            n_state      = ST_DONE;
                        end
                        default: begin
                            n_res_status = fat_pkg::STAT_NOMATCH;
                            n_state      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // The token has left the last cell: the lowest live match and
                // the lowest dead slot are now known.
                if (last_flags.active) begin
                    n_state    = ST_DONE;
                    n_res_slot = '0;
                    if (r_func == fat_pkg::FUNC_ALLOW) begin
                        if (last_flags.hit) begin
                            n_wr_en      = 1'b1;
                            n_wr_idx     = chain_hit[TABLE_ENTRIES];
                            n_res_slot   = chain_hit[TABLE_ENTRIES];
                            n_res_status = fat_pkg::STAT_STORED;
                        end else if (last_flags.free) begin
                            n_wr_en      = 1'b1;
                            n_wr_idx     = chain_free[TABLE_ENTRIES];
                            n_res_slot   = chain_free[TABLE_ENTRIES];
                            n_res_status = fat_pkg::STAT_STORED;
                        end else begin
                            n_res_status = fat_pkg::STAT_FULL;
                        end
                    end else begin
                        if (last_flags.hit) begin
                            n_res_slot   = chain_hit[TABLE_ENTRIES];
                            n_res_status = fat_pkg::STAT_ACCEPT;
                        end else begin
                            n_res_status = fat_pkg::STAT_NOMATCH;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_validity  <= fat_pkg::VALIDITY_RESET;
            r_pulse     <= 1'b0;
            r_wr_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_validity  <= n_validity;
            r_pulse     <= n_pulse;
            r_wr_en     <= n_wr_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_key_address <= n_key_address;
        r_key_port    <= n_key_port;
        r_wr_idx      <= n_wr_idx;
        r_res_status  <= n_res_status;
        r_res_slot    <= n_res_slot;
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
    end

    // The slot number leaves through its low six bits.
    assign slot_wide    = 32'(r_out_slot);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_index = slot_wide[5:0];

    // An accepted item always moves the controller out of idle.
    `FAT_ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state != ST_IDLE, "accept did not leave idle")
    // The token only reaches the end of the row during a scan.
    `FAT_ASSERT_NOW(a_token_in_scan, last_flags.active, r_state == ST_SCAN, "stray scan token")
    // Slot writes happen only in the cycle after a scan finished with a store.
    `FAT_ASSERT_NOW(a_write_after_scan, r_wr_en, (r_state == ST_DONE) && (r_res_status == fat_pkg::STAT_STORED), "unexpected slot write")
    // A new result is loaded only out of the done state.
    `FAT_ASSERT_NOW(a_result_from_done, $rose(r_out_valid), $past(r_state) == ST_DONE, "result without finished item")

endmodule

// File: sv/fat_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow allow table cell
// Holds one slot and passes the scan token on, adding its own match and free
// status when no lower slot has claimed them.
// ----------------------------------------------------------------------------
module fat_cell #(
    parameter int unsigned IW  = 6,
    parameter int unsigned IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fat_pkg::t_flags  i_flags,
    input  logic [IW-1:0]    i_hit_idx,
    input  logic [IW-1:0]    i_free_idx,
    input  logic [31:0]      i_key_address,
    input  logic [15:0]      i_key_port,
    input  logic [31:0]      i_now,
    input  logic [15:0]      i_validity,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_idx,
    output fat_pkg::t_flags  o_flags,
    output logic [IW-1:0]    o_hit_idx,
    output logic [IW-1:0]    o_free_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic            r_valid;
    logic [31:0]     r_address;
    logic [15:0]     r_port;
    logic [31:0]     r_stamp;
    fat_pkg::t_flags r_flags;
    logic [IW-1:0]   r_hit_idx;
    logic [IW-1:0]   r_free_idx;

    fat_pkg::t_flags n_flags;
    logic [IW-1:0]   n_hit_idx;
    logic [IW-1:0]   n_free_idx;
    logic [31:0]     age;
    logic            live;
    logic            match;

    // Age wraps modulo 2^32 like the seconds counter itself.
    assign age   = i_now - r_stamp;
    assign live  = r_valid && (age < {16'd0, i_validity});
    assign match = live && (r_address == i_key_address) && (r_port == i_key_port);

    always_comb begin
        n_flags.active = i_flags.active;
        n_flags.hit    = i_flags.hit | match;
        n_flags.free   = i_flags.free | !live;
        n_hit_idx      = i_flags.hit  ? i_hit_idx  : MY_IDX;
        n_free_idx     = i_flags.free ? i_free_idx : MY_IDX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
            if (i_wr_en && (i_wr_idx == MY_IDX)) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_address <= i_key_address;
            r_port    <= i_key_port;
            r_stamp   <= i_now;
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule
